@@ rtl/snfc_pkg.sv @@
// Shared types, command codes and constants for the SPI NOR flash command master.
// Used by snfc_front, snfc_back and the top module; depends on nothing else.
package snfc_pkg;

    localparam int PAGE_BYTES_DEF = 256;
    localparam int ADDR_BITS_DEF  = 24;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [23:0] EXPECTED_ID_RESET = 24'h014017;

    // op field of a request
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // command field
    localparam logic [2:0] CMD_ID      = 3'd0;
    localparam logic [2:0] CMD_READ    = 3'd1;
    localparam logic [2:0] CMD_WREN    = 3'd2;
    localparam logic [2:0] CMD_WRDI    = 3'd3;
    localparam logic [2:0] CMD_PROGRAM = 3'd4;
    localparam logic [2:0] CMD_ERASE   = 3'd5;
    localparam logic [2:0] CMD_STATUS  = 3'd6;

    // flash opcodes
    localparam logic [7:0] FL_RDID = 8'h9F;
    localparam logic [7:0] FL_READ = 8'h03;
    localparam logic [7:0] FL_WREN = 8'h06;
    localparam logic [7:0] FL_WRDI = 8'h04;
    localparam logic [7:0] FL_PP   = 8'h02;
    localparam logic [7:0] FL_SE   = 8'h20;
    localparam logic [7:0] FL_RDSR = 8'h05;

    localparam logic [15:0] ID_BYTES     = 16'd3;
    localparam logic [15:0] STATUS_BYTES = 16'd1;

    typedef enum logic [1:0] {
        REQ_NONE,
        REQ_START,
        REQ_LOAD,
        REQ_TICK
    } req_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_OPCODE,
        PH_ADDR,
        PH_DATA
    } phase_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  command;
        logic [23:0] address;
        logic [15:0] length;
        logic [7:0]  wdata;
        logic        miso;
    } snfc_in_t;

    typedef struct packed {
        logic       cs_n;
        logic       mosi;
        logic       sclk_pulse;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       id_ok;
        logic       busy_flag;
        logic       done_res;
        logic       idle;
    } snfc_out_t;

    // classified request handed from front to back
    typedef struct packed {
        req_kind_t   kind;
        logic [2:0]  command;
        logic [7:0]  opcode;
        logic [15:0] data_len;
        logic [23:0] address;
        logic [7:0]  wdata;
        logic        miso;
    } snfc_req_t;

    function automatic logic [7:0] opcode_of(input logic [2:0] cmd);
        logic [7:0] code;
        case (cmd)
            CMD_ID:      code = FL_RDID;
            CMD_READ:    code = FL_READ;
            CMD_WREN:    code = FL_WREN;
            CMD_WRDI:    code = FL_WRDI;
            CMD_PROGRAM: code = FL_PP;
            CMD_ERASE:   code = FL_SE;
            CMD_STATUS:  code = FL_RDSR;
            default:     code = 8'h00;
        endcase
        return code;
    endfunction

    function automatic logic has_address(input logic [2:0] cmd);
        return (cmd == CMD_READ) || (cmd == CMD_PROGRAM) || (cmd == CMD_ERASE);
    endfunction

endpackage

@@ rtl/snfc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module snfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/snfc_fifo.sv @@
// Small register queue used between the front and back parts and on the result side.
// Standalone; no package dependency.
module snfc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ rtl/snfc_front.sv @@
// Front part: classifies incoming requests, resolves opcode and data length,
// and queues them for the back part. Uses snfc_pkg and snfc_fifo.
module snfc_front #(
    parameter int PAGE_BYTES = snfc_pkg::PAGE_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  snfc_pkg::snfc_in_t   item,
    output logic                 full,
    input  logic                 req_pop,
    output snfc_pkg::snfc_req_t  req,
    output logic                 req_empty
);

    import snfc_pkg::*;

    snfc_req_t   cls;
    logic [15:0] page_len;
    logic [15:0] prog_len;

    assign page_len = 16'(PAGE_BYTES);
    assign prog_len = (item.length > page_len) ? page_len : item.length;

    always_comb
    begin
        cls          = '0;
        cls.command  = item.command;
        cls.opcode   = opcode_of(item.command);
        cls.address  = item.address;
        cls.wdata    = item.wdata;
        cls.miso     = item.miso;
        case (item.command)
            CMD_ID:      cls.data_len = ID_BYTES;
            CMD_STATUS:  cls.data_len = STATUS_BYTES;
            CMD_READ:    cls.data_len = item.length;
            CMD_PROGRAM: cls.data_len = prog_len;
            default:     cls.data_len = '0;
        endcase
        case (item.op)
            OP_START: cls.kind = (item.command <= CMD_STATUS) ? REQ_START : REQ_NONE;
            OP_LOAD:  cls.kind = REQ_LOAD;
            OP_TICK:  cls.kind = REQ_TICK;
            default:  cls.kind = REQ_NONE;
        endcase
    end

    snfc_fifo #(
        .WIDTH ($bits(snfc_req_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_req_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls),
        .full  (full),
        .pop   (req_pop),
        .rdata (req),
        .empty (req_empty)
    );

endmodule

@@ rtl/snfc_back.sv @@
// Back part: SPI frame sequencer with page buffer and result queue.
// Uses snfc_pkg, snfc_ram and snfc_fifo.
module snfc_back #(
    parameter int PAGE_BYTES = snfc_pkg::PAGE_BYTES_DEF,
    parameter int ADDR_BITS  = snfc_pkg::ADDR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  snfc_pkg::snfc_req_t  req,
    input  logic                 req_empty,
    output logic                 req_pop,
    input  logic [23:0]          expected_id,
    output snfc_pkg::snfc_out_t  result,
    output logic                 empty,
    input  logic                 pop
);

    import snfc_pkg::*;

    localparam int ABYTES = (ADDR_BITS + 7) / 8;
    localparam int AW8    = ABYTES * 8;
    localparam int IW     = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
    localparam int FW     = $clog2(PAGE_BYTES + 1);

    phase_t        phase_reg, phase_next;
    logic [2:0]    bit_count_reg, bit_count_next;
    logic [15:0]   byte_count_reg, byte_count_next;
    logic [7:0]    shift_out_reg, shift_out_next;
    logic [7:0]    shift_in_reg, shift_in_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic [AW8-1:0] addr_reg, addr_next;
    logic [23:0]   id_bytes_reg, id_bytes_next;
    logic          id_match_reg, id_match_next;
    logic          busy_reg, busy_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [15:0]   data_len_reg, data_len_next;

    logic          take;
    logic          res_full;
    snfc_out_t     res;
    logic          ram_we, ram_re;
    logic [IW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [7:0]    si;
    logic [23:0]   id_new;
    logic [15:0]   cnt_inc;
    logic [15:0]   rd_sum;
    logic [7:0]    data_out;
    logic          enter_data;
    logic          fin;

    assign take     = !req_empty && !res_full;
    assign req_pop  = take;
    assign si       = {shift_in_reg[6:0], req.miso};
    assign id_new   = {id_bytes_reg[15:0], si};
    assign cnt_inc  = byte_count_reg + 16'd1;
    assign rd_sum   = byte_count_reg + 16'd2;
    assign data_out = (cmd_reg == CMD_PROGRAM) ? ram_rdata : 8'h00;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        byte_count_next = byte_count_reg;
        shift_out_next  = shift_out_reg;
        shift_in_next   = shift_in_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        id_bytes_next   = id_bytes_reg;
        id_match_next   = id_match_reg;
        busy_next       = busy_reg;
        fill_next       = fill_reg;
        data_len_next   = data_len_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        enter_data      = 1'b0;
        fin             = 1'b0;
        res             = '0;
        res.cs_n        = 1'b1;

        if (take)
        begin
            case (req.kind)
                REQ_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        cmd_next        = req.command;
                        addr_next       = AW8'(req.address);
                        data_len_next   = req.data_len;
                        phase_next      = PH_OPCODE;
                        bit_count_next  = '0;
                        byte_count_next = '0;
                        shift_in_next   = '0;
                        shift_out_next  = req.opcode;
                        if (req.command == CMD_ID)
                        begin
                            id_match_next = 1'b0;
                        end
                        // prefetch the first page byte
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                    end
                end
                REQ_LOAD:
                begin
                    if (phase_reg == PH_IDLE && fill_reg < FW'(PAGE_BYTES))
                    begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                REQ_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        res.cs_n       = 1'b0;
                        res.sclk_pulse = 1'b1;
                        res.mosi       = shift_out_reg[7];
                        shift_out_next = {shift_out_reg[6:0], 1'b0};
                        shift_in_next  = si;
                        bit_count_next = bit_count_reg + 1'b1;
                        if (bit_count_reg == 3'd7)
                        begin
                            case (phase_reg)
                                PH_OPCODE:
                                begin
                                    if (has_address(cmd_reg))
                                    begin
                                        phase_next      = PH_ADDR;
                                        byte_count_next = '0;
                                        shift_out_next  = addr_reg[AW8-1 -: 8];
                                        addr_next       = {addr_reg[AW8-9:0], 8'h00};
                                    end
                                    else
                                    begin
                                        enter_data = 1'b1;
                                    end
                                end
                                PH_ADDR:
                                begin
                                    if (cnt_inc < 16'(ABYTES))
                                    begin
                                        byte_count_next = cnt_inc;
                                        shift_out_next  = addr_reg[AW8-1 -: 8];
                                        addr_next       = {addr_reg[AW8-9:0], 8'h00};
                                    end
                                    else
                                    begin
                                        enter_data = 1'b1;
                                    end
                                end
                                PH_DATA:
                                begin
                                    if (cmd_reg == CMD_READ)
                                    begin
                                        res.rx_valid = 1'b1;
                                        res.rx_byte  = si;
                                    end
                                    else if (cmd_reg == CMD_STATUS)
                                    begin
                                        res.rx_valid = 1'b1;
                                        res.rx_byte  = si;
                                        busy_next    = si[0];
                                    end
                                    else if (cmd_reg == CMD_ID)
                                    begin
                                        id_bytes_next = id_new;
                                        if (byte_count_reg == 16'd2)
                                        begin
                                            id_match_next = (id_new == expected_id);
                                        end
                                    end
                                    if (cnt_inc < data_len_reg)
                                    begin
                                        byte_count_next = cnt_inc;
                                        shift_out_next  = data_out;
                                        // fetch the byte after the one now loaded
                                        ram_re    = 1'b1;
                                        ram_raddr = rd_sum[IW-1:0];
                                    end
                                    else
                                    begin
                                        fin = 1'b1;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase

                            if (enter_data)
                            begin
                                phase_next      = PH_DATA;
                                byte_count_next = '0;
                                if (data_len_reg == '0)
                                begin
                                    fin = 1'b1;
                                end
                                else
                                begin
                                    shift_out_next = data_out;
                                    ram_re         = 1'b1;
                                    ram_raddr      = IW'(1);
                                end
                            end

                            if (fin)
                            begin
                                res.done_res    = 1'b1;
                                phase_next      = PH_IDLE;
                                byte_count_next = '0;
                                if (cmd_reg == CMD_PROGRAM)
                                begin
                                    fill_next = '0;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.id_ok     = id_match_next;
        res.busy_flag = busy_next;
        res.idle      = (phase_next == PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            byte_count_reg <= '0;
            shift_out_reg  <= '0;
            shift_in_reg   <= '0;
            cmd_reg        <= CMD_ID;
            addr_reg       <= '0;
            id_bytes_reg   <= '0;
            id_match_reg   <= 1'b0;
            busy_reg       <= 1'b0;
            fill_reg       <= '0;
            data_len_reg   <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            byte_count_reg <= byte_count_next;
            shift_out_reg  <= shift_out_next;
            shift_in_reg   <= shift_in_next;
            cmd_reg        <= cmd_next;
            addr_reg       <= addr_next;
            id_bytes_reg   <= id_bytes_next;
            id_match_reg   <= id_match_next;
            busy_reg       <= busy_next;
            fill_reg       <= fill_next;
            data_len_reg   <= data_len_next;
        end
    end

    snfc_ram #(
        .WIDTH (8),
        .DEPTH (PAGE_BYTES)
    ) u_page_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[IW-1:0]),
        .wdata (req.wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    snfc_fifo #(
        .WIDTH ($bits(snfc_out_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (take),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

@@ rtl/spi_nor_flash_command_master_top.sv @@
// SPI mode-0 NOR flash command master. Every request yields exactly one result, in order.
// A start request latches a command; each tick request shifts one SCLK bit (opcode, address,
// then data, MSB first); load requests fill the page buffer used by page program. The block
// takes one request per clock, as the back-end sequencer retires one per cycle while the
// result queue has room, with a two-entry queue on either side of it; each request is
// registered in the request queue and its result in the result queue. The page buffer is a
// RAM whose next byte is prefetched during the current byte, so program ticks run at full
// rate. The expected JEDEC ID register may be written only while no request is queued or in
// flight. Depends on snfc_pkg, snfc_front, snfc_back (and through them snfc_fifo, snfc_ram).
module spi_nor_flash_command_master_top #(
    parameter int PAGE_BYTES = snfc_pkg::PAGE_BYTES_DEF,
    parameter int ADDR_BITS  = snfc_pkg::ADDR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  snfc_pkg::snfc_in_t   item,
    output logic                 full,
    output logic                 empty,
    input  logic                 pop,
    output snfc_pkg::snfc_out_t  result,
    input  logic                 cfg_write,
    input  logic [23:0]          cfg_data
);

    import snfc_pkg::*;

    logic [23:0] expected_id_reg;
    snfc_req_t   req;
    logic        req_empty;
    logic        req_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg <= EXPECTED_ID_RESET;
        end
        else if (cfg_write)
        begin
            expected_id_reg <= cfg_data;
        end
    end

    snfc_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .req_pop   (req_pop),
        .req       (req),
        .req_empty (req_empty)
    );

    snfc_back #(
        .PAGE_BYTES (PAGE_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .req_empty   (req_empty),
        .req_pop     (req_pop),
        .expected_id (expected_id_reg),
        .result      (result),
        .empty       (empty),
        .pop         (pop)
    );

    // a shifted bit always comes with chip select low and vice versa
    a_pulse_cs: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.sclk_pulse == !result.cs_n))
        else $error("sclk_pulse and cs_n disagree");

    // no pulse means nothing driven, received or finished
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.sclk_pulse) |->
            (!result.mosi && !result.rx_valid && !result.done_res))
        else $error("activity reported without a clock pulse");

    // end of frame leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.done_res) |-> result.idle)
        else $error("frame ended but not idle");

    // receive byte is zero unless flagged valid
    a_rx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.rx_valid) |-> (result.rx_byte == 8'h00))
        else $error("rx_byte nonzero without rx_valid");

endmodule
